### rtl/core/tpc_pkg.sv
`default_nettype none
package tpc_pkg;

  // Field widths of the request and result words
  localparam int unsigned FREQ_W = 24;
  localparam int unsigned CMP_W  = 16;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_CTRL = 1'b0;

  localparam int unsigned DEF_CPU_CLOCK_HZ = 16000000;

  // Counter limits
  localparam int unsigned LIMIT_8  = 255;
  localparam int unsigned LIMIT_16 = 65535;

  typedef enum logic [2:0] {
    CS_NONE    = 3'd0,
    CS_DIV1    = 3'd1,
    CS_DIV8    = 3'd2,
    CS_DIV64   = 3'd3,
    CS_DIV256  = 3'd4,
    CS_DIV1024 = 3'd5
  } cs_t;

  localparam int unsigned NUM_PRE = 5;
  localparam int unsigned PRE_SHIFT [NUM_PRE] = '{0, 3, 6, 8, 10};
  localparam cs_t PRE_CODE [NUM_PRE] = '{CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024};

  typedef struct packed {
    logic             valid;
    cs_t              sel;
    logic [CMP_W-1:0] cmp;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/tpc_div_cell.sv
`default_nettype none
// One restoring-division step: brings in one numerator bit, yields one quotient bit.
module tpc_div_cell #(
  parameter int unsigned QUOT_W = 27,
  parameter bit          NBIT   = 1'b0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      valid_in,
  input  wire logic [tpc_pkg::FREQ_W-1:0] div_in,
  input  wire logic [tpc_pkg::FREQ_W-1:0] rem_in,
  input  wire logic [QUOT_W-1:0]         quot_in,
  output logic                           valid_out,
  output logic [tpc_pkg::FREQ_W-1:0]     div_out,
  output logic [tpc_pkg::FREQ_W-1:0]     rem_out,
  output logic [QUOT_W-1:0]              quot_out
);
  import tpc_pkg::*;

  logic              valid_r;
  logic [FREQ_W-1:0] div_r, rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [FREQ_W:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_in, NBIT};
    diff  = trial - {1'b0, div_in};
    ge    = trial >= {1'b0, div_in};
    // both arms stay below the divisor, so the top bit drops
    rem_nxt  = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    quot_nxt = {quot_in[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r  <= div_in;
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign valid_out = valid_r;
  assign div_out   = div_r;
  assign rem_out   = rem_r;
  assign quot_out  = quot_r;

endmodule
`default_nettype wire

### rtl/core/tpc_pick.sv
`default_nettype none
// Rounds floor(2*clock/f) for each prescaler and takes the first that fits.
module tpc_pick #(
  parameter int unsigned QUOT_W = 27
) (
  input  wire logic                       is16,
  input  wire logic [tpc_pkg::FREQ_W-1:0] div,
  input  wire logic [QUOT_W-1:0]          quot,
  output tpc_pkg::res_t                   res
);
  import tpc_pkg::*;

  logic [QUOT_W:0] qx;
  logic [QUOT_W:0] q;
  logic [31:0]     lim;

  always_comb begin
    qx  = '0;
    q   = '0;
    lim = is16 ? 32'(LIMIT_16) : 32'(LIMIT_8);
    res = '{valid: 1'b0, sel: CS_NONE, cmp: '0};
    // walk from the largest prescaler down so the smallest fit wins
    for (int n = NUM_PRE - 1; n >= 0; n--) begin
      qx = ({1'b0, quot} >> PRE_SHIFT[n]) + 1'b1;
      q  = qx >> 1;
      if (q != '0 && 32'(q - 1'b1) <= lim) begin
        res.valid = 1'b1;
        res.sel   = PRE_CODE[n];
        res.cmp   = CMP_W'(q - 1'b1);
      end
    end
    // zero frequency is rejected
    if (div == '0) begin
      res = '{valid: 1'b0, sel: CS_NONE, cmp: '0};
    end
  end

endmodule
`default_nettype wire

### rtl/core/timer_prescaler_compare_calc_core.sv
`default_nettype none
// Timer prescaler and compare-value finder. Each request word carries a
// frequency f in hertz; the block returns the first of the prescalers /1,
// /8, /64, /256, /1024 whose compare value round(CPU_CLOCK_HZ/(p*f))-1
// (halves round up) fits the counter limit, 255 or 65535 per the
// counter_is_16bit bit of the control register at address 0. One request is
// taken every cycle unless the output is stalled. floor(2*CPU_CLOCK_HZ/f)
// comes from a row of $clog2(2*CPU_CLOCK_HZ+1) restoring division cells,
// one quotient bit per cell, followed by one output register. A zero
// frequency, a frequency above twice the clock, or no fitting prescaler
// yields valid_res=0 with zero fields. A stalled valid output holds the
// whole row; the input stalls only then.
module timer_prescaler_compare_calc_core #(
  parameter int unsigned CPU_CLOCK_HZ = tpc_pkg::DEF_CPU_CLOCK_HZ
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [tpc_pkg::FREQ_W-1:0] in_desired_frequency,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_valid_res,
  output logic [2:0]                      out_clock_select,
  output logic [tpc_pkg::CMP_W-1:0]       out_compare_value,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tpc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tpc_pkg::DATA_W-1:0] pwdata,
  output logic [tpc_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import tpc_pkg::*;

  localparam int unsigned QUOT_W = $clog2(2 * CPU_CLOCK_HZ + 1);
  localparam logic [QUOT_W-1:0] NUMER = QUOT_W'(2 * CPU_CLOCK_HZ);

  logic is16_r;
  logic adv;

  logic              c_valid [QUOT_W+1];
  logic [FREQ_W-1:0] c_div   [QUOT_W+1];
  logic [FREQ_W-1:0] c_rem   [QUOT_W+1];
  logic [QUOT_W-1:0] c_quot  [QUOT_W+1];

  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is16_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_CTRL) begin
      is16_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_CTRL) ? DATA_W'(is16_r) : '0;

  // the whole row advances unless the output word is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  assign c_valid[0] = in_valid;
  assign c_div[0]   = in_desired_frequency;
  assign c_rem[0]   = '0;
  assign c_quot[0]  = '0;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
    tpc_div_cell #(
      .QUOT_W (QUOT_W),
      .NBIT   (NUMER[QUOT_W-1-k])
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (c_valid[k]),
      .div_in    (c_div[k]),
      .rem_in    (c_rem[k]),
      .quot_in   (c_quot[k]),
      .valid_out (c_valid[k+1]),
      .div_out   (c_div[k+1]),
      .rem_out   (c_rem[k+1]),
      .quot_out  (c_quot[k+1])
    );
  end

  tpc_pick #(
    .QUOT_W (QUOT_W)
  ) u_pick (
    .is16 (is16_r),
    .div  (c_div[QUOT_W]),
    .quot (c_quot[QUOT_W]),
    .res  (res)
  );

  assign out_valid_nxt = adv ? c_valid[QUOT_W] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = out_res_r.valid;
  assign out_clock_select  = out_res_r.sel;
  assign out_compare_value = out_res_r.cmp;

  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.valid |-> out_res_r.sel == CS_NONE && out_res_r.cmp == '0)
    else $error("rejected word carries nonzero fields");

  a_sel_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.valid |-> out_res_r.sel != CS_NONE)
    else $error("accepted word has no clock select");

  a_limit8 : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.valid && !is16_r |-> 32'(out_res_r.cmp) <= LIMIT_8)
    else $error("compare value exceeds 8-bit limit");

  a_hold_row : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(c_quot[QUOT_W]) && $stable(c_valid[QUOT_W]))
    else $error("division row moved while output held");

endmodule
`default_nettype wire
